// ----- hdl/mmh_pkg.sv -----
// Shared types, state codes and helper functions for the multiply-mix hash engine.
// No dependencies; every other file in hdl/ imports this package.
package mmh_pkg;

  typedef logic [63:0] word_t;

  // One queued block, already classified by the front end.
  typedef struct packed {
    word_t      word_a;
    word_t      word_b;
    word_t      word_c;
    word_t      word_d;
    word_t      seed_even;
    word_t      seed_odd;
    logic       first;
    logic       bank;
    logic       last;
  } entry_t;

  // Front end status seen by the top level.
  typedef struct packed {
    logic       next_bank;
    logic       push;
  } front_stat_t;

  // Queue status seen by the top level.
  typedef struct packed {
    logic [1:0] count;
    logic       pop;
  } queue_stat_t;

  // Back end sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MIX  = 3'd1;
  localparam logic [2:0] ST_FX   = 3'd2;
  localparam logic [2:0] ST_FY   = 3'd3;
  localparam logic [2:0] ST_FZ   = 3'd4;
  localparam logic [2:0] ST_FW   = 3'd5;
  localparam logic [2:0] ST_HASH = 3'd6;

  typedef struct packed {
    logic [2:0] state;
  } back_stat_t;

  localparam int unsigned QueueDepth = 2;

  // Swap the two 32-bit halves of a word.
  function automatic word_t rot32(input word_t v);
    return {v[31:0], v[63:32]};
  endfunction

endpackage

// ----- hdl/multiply_mix_hash64_engine_unit.sv -----
// Top level of the multiply-mix 64-bit hash engine: front end, block queue and back end.
// Depends on mmh_pkg, mmh_front, mmh_queue and mmh_back.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------------------
//   in      | input     | in_valid / in_stall | word_a..word_d, seed_even, seed_odd, flags
//   out     | output    | out_valid/out_stall | hash_value
//   cfg     | input     | cfg_we              | cfg_addr (init_vec index), cfg_data
//
// In the back end an ordinary block is popped and added to the block words, then each
// lane passes in turn through the single shared 32x32 multiplier. A last block then
// runs the merge and fold, with 6 more multiplier passes.
// The two-entry queue lets the front end keep taking items while the back end works,
// and the output register holds a finished hash under out_stall without blocking input.
// Reset (rst, synchronous) clears the banks, the bank toggle and the initial vector.
module multiply_mix_hash64_engine_unit
  import mmh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_addr,
  input  word_t      cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  word_t      word_a,
  input  word_t      word_b,
  input  word_t      word_c,
  input  word_t      word_d,
  input  word_t      seed_even,
  input  word_t      seed_odd,
  input  logic       first_block,
  input  logic       start_bank,
  input  logic       last_block,
  output logic       out_valid,
  input  logic       out_stall,
  output word_t      hash_value
);

  logic        q_full;
  logic        q_avail;
  logic        push;
  logic        pop;
  entry_t      push_entry;
  entry_t      q_head;
  front_stat_t front_stat;
  queue_stat_t queue_stat;
  back_stat_t  back_stat;

  // The front end decides the bank of each block as it arrives, so the bank toggle
  // runs ahead of the back end by up to the depth of the queue.
  mmh_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .word_a      (word_a),
    .word_b      (word_b),
    .word_c      (word_c),
    .word_d      (word_d),
    .seed_even   (seed_even),
    .seed_odd    (seed_odd),
    .first_block (first_block),
    .start_bank  (start_bank),
    .last_block  (last_block),
    .q_full      (q_full),
    .push        (push),
    .entry       (push_entry),
    .stat        (front_stat)
  );

  mmh_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .avail      (q_avail),
    .head       (q_head),
    .stat       (queue_stat)
  );

  // The back end seeds both banks on a first block, then mixes into the chosen bank.
  mmh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .q_avail    (q_avail),
    .q_head     (q_head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hash_value (hash_value),
    .stat       (back_stat)
  );

  // The queue never holds more items than it has entries.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    queue_stat.count <= 2'(QueueDepth))
    else $error("block queue overflow");

  // After a last block is accepted the bank toggle points to bank one.
  a_bank_after_last: assert property (@(posedge clk) disable iff (rst)
    (front_stat.push && last_block) |=> front_stat.next_bank)
    else $error("bank toggle wrong after last block");

  // A new hash appears only at the end of the fold sequence.
  a_hash_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(back_stat.state == ST_HASH))
    else $error("hash emitted outside the fold sequence");

  // Blocks leave the queue only while the back end is idle.
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    queue_stat.pop |-> (back_stat.state == ST_IDLE))
    else $error("block popped while back end busy");

endmodule

// ----- hdl/mmh_front.sv -----
// Front end: accepts input items, picks the bank for each block and pushes it to the queue.
// Depends on mmh_pkg.
module mmh_front
  import mmh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  word_t       word_a,
  input  word_t       word_b,
  input  word_t       word_c,
  input  word_t       word_d,
  input  word_t       seed_even,
  input  word_t       seed_odd,
  input  logic        first_block,
  input  logic        start_bank,
  input  logic        last_block,
  input  logic        q_full,
  output logic        push,
  output entry_t      entry,
  output front_stat_t stat
);

  logic next_bank;
  logic bank_sel;

  // The last block always goes to bank zero; a first block picks its own bank.
  always_comb begin
    priority if (last_block) begin
      bank_sel = 1'b0;
    end else if (first_block) begin
      bank_sel = start_bank;
    end else begin
      bank_sel = next_bank;
    end
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    entry.word_a    = word_a;
    entry.word_b    = word_b;
    entry.word_c    = word_c;
    entry.word_d    = word_d;
    entry.seed_even = seed_even;
    entry.seed_odd  = seed_odd;
    entry.first     = first_block;
    entry.bank      = bank_sel;
    entry.last      = last_block;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_bank <= 1'b0;
    end else if (push) begin
      next_bank <= ~bank_sel;
    end
  end

  assign stat.next_bank = next_bank;
  assign stat.push      = push;

endmodule

// ----- hdl/mmh_queue.sv -----
// Two-entry queue of classified blocks between the front end and the back end.
// Depends on mmh_pkg.
module mmh_queue
  import mmh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  entry_t      push_entry,
  input  logic        pop,
  output logic        full,
  output logic        avail,
  output entry_t      head,
  output queue_stat_t stat
);

  entry_t     mem [QueueDepth];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = (count == 2'(QueueDepth));
  assign avail = (count != 2'd0);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign stat.count = count;
  assign stat.pop   = pop;

endmodule

// ----- hdl/mmh_back.sv -----
// Back end: holds the banks and initial vector, mixes blocks and folds the final hash
// with one shared 32x32 multiplier. Depends on mmh_pkg.
module mmh_back
  import mmh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_addr,
  input  word_t      cfg_data,
  input  logic       q_avail,
  input  entry_t     q_head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output word_t      hash_value,
  output back_stat_t stat
);

  word_t      init_vec  [8];
  word_t      bank_zero [4];
  word_t      bank_one  [4];
  word_t      xr [4];
  word_t      yr [4];
  word_t      prod;
  logic [2:0] state;
  logic [1:0] idx;
  logic       phase;
  logic       cur_bank;
  logic       cur_last;

  word_t      words  [4];
  word_t      seed0  [4];
  word_t      seed1  [4];
  word_t      src    [4];
  word_t      operand;
  word_t      partner;
  word_t      mul_out;
  word_t      sum;
  logic       out_free;

  assign pop      = (state == ST_IDLE) && q_avail;
  assign out_free = !out_valid || !out_stall;

  // Seeded lane values and the lanes a popped block is mixed into.
  always_comb begin
    words[0] = q_head.word_a;
    words[1] = q_head.word_b;
    words[2] = q_head.word_c;
    words[3] = q_head.word_d;
    for (int i = 0; i < 4; i++) begin
      seed0[i] = (i[0] ? q_head.seed_odd : q_head.seed_even) ^ init_vec[i];
      seed1[i] = (i[0] ? q_head.seed_odd : q_head.seed_even) ^ init_vec[4 + i];
      if (q_head.first) begin
        src[i] = q_head.bank ? seed1[i] : seed0[i];
      end else begin
        src[i] = q_head.bank ? bank_one[i] : bank_zero[i];
      end
    end
  end

  // Shared multiply-add: the product is registered, the add happens next cycle.
  assign operand = xr[idx];
  assign partner = xr[idx ^ 2'd1];
  assign mul_out = {32'd0, operand[31:0]} * {32'd0, operand[63:32]};
  assign sum     = prod + ((state == ST_MIX) ? rot32(partner) : partner);

  // The output register is loaded when the fold ends and the previous hash is gone.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_HASH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= 2'd0;
      phase     <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        init_vec[i] <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        bank_zero[i] <= '0;
        bank_one[i]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        init_vec[cfg_addr] <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_avail) begin
            if (q_head.first) begin
              for (int i = 0; i < 4; i++) begin
                bank_zero[i] <= seed0[i];
                bank_one[i]  <= seed1[i];
              end
            end
            idx   <= 2'd0;
            phase <= 1'b0;
            state <= ST_MIX;
          end
        end
        ST_MIX: begin
          phase <= ~phase;
          if (phase) begin
            if (cur_bank) begin
              bank_one[idx] <= sum;
            end else begin
              bank_zero[idx] <= sum;
            end
            idx <= idx + 2'd1;
            if (idx == 2'd3) begin
              state <= cur_last ? ST_FX : ST_IDLE;
            end
          end
        end
        ST_FX: begin
          idx   <= 2'd0;
          phase <= 1'b0;
          state <= ST_FY;
        end
        ST_FY: begin
          phase <= ~phase;
          if (phase) begin
            idx <= idx + 2'd1;
            if (idx == 2'd3) begin
              state <= ST_FZ;
            end
          end
        end
        ST_FZ: begin
          idx   <= 2'd0;
          phase <= 1'b0;
          state <= ST_FW;
        end
        ST_FW: begin
          phase <= ~phase;
          if (phase) begin
            idx <= idx + 2'd1;
            if (idx == 2'd1) begin
              state <= ST_HASH;
            end
          end
        end
        ST_HASH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < 4; i++) begin
        xr[i] <= src[i] + words[i];
      end
      cur_bank <= q_head.bank;
      cur_last <= q_head.last;
    end
    if (!phase) begin
      prod <= mul_out;
    end
    if (state == ST_FX) begin
      for (int i = 0; i < 4; i++) begin
        xr[i] <= bank_zero[i] + rot32(bank_one[i ^ 1]);
      end
    end
    if ((state == ST_FY || state == ST_FW) && phase) begin
      yr[idx] <= sum;
    end
    if (state == ST_FZ) begin
      xr[0] <= yr[0] + rot32(yr[3]);
      xr[1] <= yr[1] + rot32(yr[2]);
    end
    if (state == ST_HASH && out_free) begin
      hash_value <= yr[0] + rot32(yr[1]);
    end
  end

  assign stat.state = state;

endmodule
